>>> design/kdlp_pkg.sv
// Shared types and constants for the key debounce / long-press block.
package kdlp_pkg;

    // Key port decode
    localparam logic [7:0] KEY_MASK      = 8'hb4;
    localparam logic [7:0] PAT_KEY_2     = 8'hb0;
    localparam logic [7:0] PAT_KEY_4     = 8'ha4;
    localparam logic [7:0] PAT_KEY_5     = 8'h94;
    localparam logic [7:0] PAT_KEY_POWER = 8'h34;

    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_2     = 3'd2;
    localparam logic [2:0] KEY_4     = 3'd4;
    localparam logic [2:0] KEY_5     = 3'd5;
    localparam logic [2:0] KEY_POWER = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_TICKS     = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_SECOND   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_SECONDS = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_DEBOUNCE_TICKS     = 8'd5;
    localparam logic [7:0] RST_TICKS_PER_SECOND   = 8'd100;
    localparam logic [2:0] RST_LONG_PRESS_SECONDS = 3'd3;

    // One result item
    typedef struct packed {
        logic       event_long;
        logic [2:0] event_key;
        logic       event_valid;
    } key_event_t;

    function automatic logic [2:0] decode_port(input logic [7:0] sample);
        logic [2:0] key;
        case (sample & KEY_MASK)
            PAT_KEY_2:     key = KEY_2;
            PAT_KEY_4:     key = KEY_4;
            PAT_KEY_5:     key = KEY_5;
            PAT_KEY_POWER: key = KEY_POWER;
            default:       key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

>>> design/kdlp_core.sv
// Press timing state, configuration registers and per-tick event logic.
module kdlp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [7:0]          cfg_wdata,
    input  logic                step,
    input  logic [7:0]          port_sample,
    output kdlp_pkg::key_event_t ev
);
    import kdlp_pkg::*;

    logic [7:0] debounce_reg;
    logic [7:0] tps_reg;
    logic [2:0] lps_reg;

    logic [2:0] held_key_reg,      held_key_next;
    logic       press_counting_reg, press_counting_next;
    logic [7:0] hold_ticks_reg,    hold_ticks_next;
    logic [2:0] hold_seconds_reg,  hold_seconds_next;
    logic       long_reported_reg, long_reported_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= RST_DEBOUNCE_TICKS;
            tps_reg      <= RST_TICKS_PER_SECOND;
            lps_reg      <= RST_LONG_PRESS_SECONDS;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEBOUNCE_TICKS:     debounce_reg <= cfg_wdata;
                CFG_TICKS_PER_SECOND:   tps_reg      <= cfg_wdata;
                CFG_LONG_PRESS_SECONDS: lps_reg      <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Next state and event for the current tick
    always_comb begin
        logic [2:0] key;
        logic       counting;
        logic [2:0] secs_inc;
        key                 = decode_port(port_sample);
        held_key_next       = held_key_reg;
        press_counting_next = press_counting_reg;
        hold_ticks_next     = hold_ticks_reg;
        hold_seconds_next   = hold_seconds_reg;
        long_reported_next  = long_reported_reg;
        ev                  = '0;
        secs_inc            = 3'd0;

        // key change: release or start of a new press
        if (key != held_key_reg) begin
            if (key == KEY_NONE) begin
                press_counting_next = 1'b0;
                if (held_key_reg == KEY_POWER) begin
                    if (long_reported_reg) begin
                        long_reported_next = 1'b0;
                    end else if (hold_seconds_reg != 3'd0 ||
                                 hold_ticks_reg > debounce_reg) begin
                        ev.event_valid = 1'b1;
                        ev.event_key   = KEY_POWER;
                    end
                end
            end else begin
                press_counting_next = 1'b1;
                hold_ticks_next     = 8'd0;
                hold_seconds_next   = 3'd0;
            end
            held_key_next = key;
        end

        // press timing
        counting = press_counting_next;
        if (counting) begin
            if (hold_ticks_next == debounce_reg) begin
                if (held_key_next != KEY_POWER) begin
                    press_counting_next = 1'b0;
                    ev.event_valid      = 1'b1;
                    ev.event_key        = held_key_next;
                end
            end else if (hold_ticks_next == tps_reg) begin
                secs_inc = hold_seconds_next + 3'd1;
                if (secs_inc == lps_reg) begin
                    long_reported_next  = 1'b1;
                    hold_seconds_next   = 3'd0;
                    press_counting_next = 1'b0;
                    ev.event_valid      = 1'b1;
                    ev.event_key        = held_key_next;
                    ev.event_long       = 1'b1;
                end else begin
                    hold_seconds_next = secs_inc;
                    hold_ticks_next   = 8'd0;
                end
            end
            hold_ticks_next = hold_ticks_next + 8'd1;
        end
    end

    // State update on each processed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_key_reg       <= KEY_NONE;
            press_counting_reg <= 1'b0;
            hold_ticks_reg     <= 8'd0;
            hold_seconds_reg   <= 3'd0;
            long_reported_reg  <= 1'b0;
        end else if (step) begin
            held_key_reg       <= held_key_next;
            press_counting_reg <= press_counting_next;
            hold_ticks_reg     <= hold_ticks_next;
            hold_seconds_reg   <= hold_seconds_next;
            long_reported_reg  <= long_reported_next;
        end
    end

endmodule

>>> design/key_debounce_long_press.sv
// Top level: key debounce with long-press detection on a streaming interface.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[7:0] = port_sample
//  m_        out  m_tvalid/m_tready  m_tdata[7:0] = event_valid, event_key, event_long
//  cfg_      in   cfg_we             cfg_addr, cfg_wdata
//
// One transaction in each cycle while m_tready stays high; a tick is taken into the input
// register, then the event logic feeds the result register.
// aresetn is synchronous, active low; it clears the press state and loads the
// default timing registers.
// A stalled result register holds; the input register still takes a tick
// whenever it is empty or moves on in the same cycle.
module key_debounce_long_press (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] port_sample
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] event_valid, [3:1] event_key, [4] event_long, [7:5] 0
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);
    import kdlp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    key_event_t out_ev_reg;
    key_event_t ev;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    kdlp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .step        (advance),
        .port_sample (in_data_reg),
        .ev          (ev)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ev_reg <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_ev_reg};

endmodule

>>> design/kdlp_checker.sv
// Port-level assertions for the key debounce block, bound to the top level.
module kdlp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import kdlp_pkg::*;

    // no result and an open input right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid && s_tready)
        else $error("not idle right after reset");

    // stalled result holds
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no event means empty key and long fields
    a_empty_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
        else $error("fields set without an event");

    // events carry a real key code
    a_key_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            (m_tdata[3:1] == KEY_2 || m_tdata[3:1] == KEY_4 ||
             m_tdata[3:1] == KEY_5 || m_tdata[3:1] == KEY_POWER) &&
            m_tdata[7:5] == 3'd0)
        else $error("event with bad key code");

    // long flag only on a reported event
    a_long_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[0])
        else $error("long press flag without an event");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
